FILE: design/dzpu_pkg.sv
// Shared types and constants for the zone pixel upscaler.
// No dependencies; used by every module of the block.
package dzpu_pkg;

  localparam int COLOR_W = 16;
  localparam int COORD_W = 10;
  localparam int ZONE_W  = 5;
  localparam int PIXEL_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] RED_MASK   = 8'hF8;
  localparam logic [7:0] GREEN_MASK = 8'hFC;
  localparam logic [COLOR_W-1:0] BLACK565 = 16'h0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALING_MODE    = 2'd0,
    CFG_INPUT_FORMAT    = 2'd1,
    CFG_VERTICAL_OFFSET = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_FULL        = 2'd0,
    MODE_INNER       = 2'd1,
    MODE_LOWER_RIGHT = 2'd2,
    MODE_DIAGONAL    = 2'd3
  } mode_t;

  typedef enum logic {
    FMT_RGB888 = 1'b0,
    FMT_RGB565 = 1'b1
  } fmt_t;

  // One classified source pixel, handed from front to back.
  typedef struct packed {
    mode_t              mode;
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic               zone_end;
  } job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [COLOR_W-1:0] to_rgb565(input fmt_t fmt,
                                                   input logic [PIXEL_W-1:0] px);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = px[23:16] & RED_MASK;
    g = px[15:8] & GREEN_MASK;
    b = px[7:0];
    if (fmt == FMT_RGB565) begin
      return px[15:0];
    end
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

FILE: design/dmd_zone_pixel_upscaler.sv
// Top level of the zone pixel upscaler: front end, job queue and back end.
// Depends on dzpu_pkg, dzpu_front, dzpu_job_fifo and dzpu_back.
//
//   channel  direction  payload (low bit first)                      sideband
//   in_      slave      tdata: zone_index[4:0], pixel_data[28:5]     -
//   out_     master     tdata: out_color[15:0], panel_x[25:16],      tlast: last_of_block
//                              panel_y[35:26]                        tuser: last_of_zone
//   cfg_     write      index 0 scaling_mode, 1 input_format,        -
//                       2 vertical_offset
//
// Each source pixel gives SCALE*SCALE output transactions (16 by default), one
// per cycle from the back end's block walker unless the output beat is stalled.
// Into an idle block, an input pixel passes the queue and the walker's job
// register before out_tvalid rises from the output register.
// Reset is synchronous; it clears the configuration registers, position
// counters and queue. The two-entry queue takes new pixels while the back end
// is busy or its output is stalled; in_tready drops only when the queue is full.
module dmd_zone_pixel_upscaler #(
  parameter int SCALE        = 4,
  parameter int ZONE_COLS    = 16,
  parameter int ZONE_ROWS    = 8,
  parameter int ZONES_ACROSS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dzpu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dzpu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,   // zone_index, pixel_data, pad
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [39:0]                      out_tdata,  // out_color, panel_x, panel_y, pad
  output logic                             out_tlast,
  output logic                             out_tuser   // last_of_zone
);

  logic                         accept;
  dzpu_pkg::job_t               front_job;
  dzpu_pkg::job_t               q_job;
  dzpu_pkg::q_status_t          q_status;
  logic                         pop;
  logic [dzpu_pkg::COLOR_W-1:0] color;
  logic [dzpu_pkg::COORD_W-1:0] px;
  logic [dzpu_pkg::COORD_W-1:0] py;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;

  dzpu_front #(
    .SCALE        (SCALE),
    .ZONE_COLS    (ZONE_COLS),
    .ZONE_ROWS    (ZONE_ROWS),
    .ZONES_ACROSS (ZONES_ACROSS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .zone_index (in_tdata[4:0]),
    .pixel_data (in_tdata[28:5]),
    .job        (front_job)
  );

  dzpu_job_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (accept),
    .wr_job (front_job),
    .pop    (pop),
    .rd_job (q_job),
    .status (q_status)
  );

  dzpu_back #(
    .SCALE (SCALE)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .q_job         (q_job),
    .pop           (pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_color     (color),
    .panel_x       (px),
    .panel_y       (py),
    .last_of_block (out_tlast),
    .last_of_zone  (out_tuser)
  );

  assign out_tdata = {4'b0000, py, px, color};

endmodule

FILE: design/dzpu_front.sv
// Front end: configuration registers, source position counters, color
// conversion and block origin. Depends on dzpu_pkg.
module dzpu_front #(
  parameter int SCALE        = 4,
  parameter int ZONE_COLS    = 16,
  parameter int ZONE_ROWS    = 8,
  parameter int ZONES_ACROSS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dzpu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dzpu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              accept,
  input  logic [dzpu_pkg::ZONE_W-1:0]       zone_index,
  input  logic [dzpu_pkg::PIXEL_W-1:0]      pixel_data,
  output dzpu_pkg::job_t                    job
);

  localparam int CW = (ZONE_COLS > 1) ? $clog2(ZONE_COLS) : 1;
  localparam int RW = (ZONE_ROWS > 1) ? $clog2(ZONE_ROWS) : 1;
  localparam int NZ = 1 << dzpu_pkg::ZONE_W;
  localparam int XZ = ZONE_COLS * SCALE;
  localparam int YZ = ZONE_ROWS * SCALE;

  dzpu_pkg::mode_t       mode_r;
  dzpu_pkg::fmt_t        fmt_r;
  logic [7:0]            voff_r;
  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  logic                  col_wrap;
  logic                  row_wrap;

  logic [dzpu_pkg::ZONE_W-1:0] zcol_tab [NZ];
  logic [dzpu_pkg::ZONE_W-1:0] zrow_tab [NZ];
  logic [dzpu_pkg::ZONE_W-1:0] zcol;
  logic [dzpu_pkg::ZONE_W-1:0] zrow;
  int unsigned                 x_sum;
  int unsigned                 y_sum;

  // zone -> (column, row) of zones, fixed at elaboration
  for (genvar g = 0; g < NZ; g++) begin : g_zone_tab
    assign zcol_tab[g] = dzpu_pkg::ZONE_W'(g % ZONES_ACROSS);
    assign zrow_tab[g] = dzpu_pkg::ZONE_W'(g / ZONES_ACROSS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dzpu_pkg::MODE_FULL;
      fmt_r  <= dzpu_pkg::FMT_RGB888;
      voff_r <= '0;
    end else if (cfg_we) begin
      case (dzpu_pkg::cfg_idx_t'(cfg_index))
        dzpu_pkg::CFG_SCALING_MODE:    mode_r <= dzpu_pkg::mode_t'(cfg_wdata[1:0]);
        dzpu_pkg::CFG_INPUT_FORMAT:    fmt_r  <= dzpu_pkg::fmt_t'(cfg_wdata[0]);
        dzpu_pkg::CFG_VERTICAL_OFFSET: voff_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign col_wrap = (col_r == CW'(ZONE_COLS - 1));
  assign row_wrap = (row_r == RW'(ZONE_ROWS - 1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign zcol = zcol_tab[zone_index];
  assign zrow = zrow_tab[zone_index];

  always_comb begin
    x_sum = 32'(zcol) * XZ + 32'(col_r) * SCALE;
    y_sum = 32'(zrow) * YZ + 32'(voff_r) + 32'(row_r) * SCALE;
    job.mode     = mode_r;
    job.color    = dzpu_pkg::to_rgb565(fmt_r, pixel_data);
    job.x0       = x_sum[dzpu_pkg::COORD_W-1:0];
    job.y0       = y_sum[dzpu_pkg::COORD_W-1:0];
    job.zone_end = col_wrap && row_wrap;
  end

endmodule

FILE: design/dzpu_job_fifo.sv
// Two-entry queue of classified pixels between front and back.
// Depends on dzpu_pkg.
module dzpu_job_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dzpu_pkg::job_t       wr_job,
  input  logic                 pop,
  output dzpu_pkg::job_t       rd_job,
  output dzpu_pkg::q_status_t  status
);

  dzpu_pkg::job_t mem [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  assign rd_job = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !push)
    else $error("push into full job queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.empty |-> !pop)
    else $error("pop from empty job queue");
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");

endmodule

FILE: design/dzpu_back.sv
// Back end: walks the SCALE x SCALE block of one queued pixel, applies the
// dot mask and drives the registered output beat. Depends on dzpu_pkg.
module dzpu_back #(
  parameter int SCALE = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dzpu_pkg::q_status_t           q_status,
  input  dzpu_pkg::job_t                q_job,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dzpu_pkg::COLOR_W-1:0]  out_color,
  output logic [dzpu_pkg::COORD_W-1:0]  panel_x,
  output logic [dzpu_pkg::COORD_W-1:0]  panel_y,
  output logic                          last_of_block,
  output logic                          last_of_zone
);

  localparam int SW = $clog2(SCALE);

  dzpu_pkg::job_t               cur_r;
  logic                         active_r;
  logic [SW-1:0]                i_r, i_nxt;
  logic [SW-1:0]                j_r, j_nxt;
  logic                         advance;
  logic                         last_beat;
  logic                         lit;
  logic [SW:0]                  ij_sum;

  logic                         out_valid_r;
  logic [dzpu_pkg::COLOR_W-1:0] out_color_r;
  logic [dzpu_pkg::COORD_W-1:0] out_x_r;
  logic [dzpu_pkg::COORD_W-1:0] out_y_r;
  logic                         out_last_r;
  logic                         out_zone_r;

  assign advance   = active_r && (!out_valid_r || out_ready);
  assign last_beat = (i_r == SW'(SCALE - 1)) && (j_r == SW'(SCALE - 1));
  assign pop       = !q_status.empty && (!active_r || (advance && last_beat));
  assign ij_sum    = {1'b0, i_r} + {1'b0, j_r};

  always_comb begin
    case (cur_r.mode)
      dzpu_pkg::MODE_INNER:
        lit = (i_r != '0) && (i_r != SW'(SCALE - 1)) &&
              (j_r != '0) && (j_r != SW'(SCALE - 1));
      dzpu_pkg::MODE_LOWER_RIGHT:
        lit = (i_r != '0) && (j_r != '0);
      dzpu_pkg::MODE_DIAGONAL:
        lit = (i_r == j_r) || (ij_sum == (SW + 1)'(SCALE - 1));
      default:
        lit = 1'b1;
    endcase
  end

  // column offset outer, row offset inner
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (pop) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (advance) begin
      if (j_r == SW'(SCALE - 1)) begin
        j_nxt = '0;
        i_nxt = i_r + SW'(1);
      end else begin
        j_nxt = j_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
      if (pop) begin
        active_r <= 1'b1;
      end else if (advance && last_beat) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_color_r <= lit ? cur_r.color : dzpu_pkg::BLACK565;
      out_x_r     <= cur_r.x0 + dzpu_pkg::COORD_W'(i_r);
      out_y_r     <= cur_r.y0 + dzpu_pkg::COORD_W'(j_r);
      out_last_r  <= last_beat;
      out_zone_r  <= last_beat && cur_r.zone_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_color     = out_color_r;
  assign panel_x       = out_x_r;
  assign panel_y       = out_y_r;
  assign last_of_block = out_last_r;
  assign last_of_zone  = out_zone_r;

  a_zone_implies_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zone_r) |-> out_last_r)
    else $error("zone end flagged on a beat that does not end its block");
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && last_beat && !pop) |=> !active_r)
    else $error("walker still active after final beat");
  a_fresh_job_starts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (active_r && i_r == '0 && j_r == '0))
    else $error("new pixel does not start at block origin");

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for dmd_zone_pixel_upscaler: directed table, then random zone runs.
// Expected panel pixels come from an in-bench model of the upscaler; depends on dzpu_pkg.
`timescale 1ns / 100ps

module tb_top;

  localparam int SCALE        = 4;
  localparam int ZONE_COLS    = 16;
  localparam int ZONE_ROWS    = 8;
  localparam int ZONES_ACROSS = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 56;

  typedef struct packed {
    logic [dzpu_pkg::COLOR_W-1:0] color;
    logic [dzpu_pkg::COORD_W-1:0] x;
    logic [dzpu_pkg::COORD_W-1:0] y;
    logic                         lob;
    logic                         loz;
  } panel_px_t;

  // One row of the directed table: a register write or a source pixel.
  // Typed rows carry the converted color and block origin read off by hand.
  typedef struct packed {
    logic                         is_cfg;
    dzpu_pkg::cfg_idx_t           idx;
    logic [7:0]                   val;
    logic [dzpu_pkg::ZONE_W-1:0]  zone;
    logic [dzpu_pkg::PIXEL_W-1:0] px;
    logic                         typed;
    logic [dzpu_pkg::COLOR_W-1:0] t_color;
    logic [dzpu_pkg::COORD_W-1:0] t_x0;
    logic [dzpu_pkg::COORD_W-1:0] t_y0;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n       = 1'b0;
  logic                            cfg_we      = 1'b0;
  logic [dzpu_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [dzpu_pkg::CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [31:0]                     in_tdata    = '0;  // zone_index, pixel_data, pad
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic [39:0]                     out_tdata;         // out_color, panel_x, panel_y, pad
  logic                            out_tlast;
  logic                            out_tuser;         // last_of_zone

  dmd_zone_pixel_upscaler #(
    .SCALE(SCALE),
    .ZONE_COLS(ZONE_COLS),
    .ZONE_ROWS(ZONE_ROWS),
    .ZONES_ACROSS(ZONES_ACROSS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser)
  );

  // Model state and register copies
  dzpu_pkg::mode_t cur_mode = dzpu_pkg::MODE_FULL;
  dzpu_pkg::fmt_t  cur_fmt  = dzpu_pkg::FMT_RGB888;
  logic [7:0]      cur_voff = 8'd0;
  logic [3:0]      src_col  = '0;
  logic [2:0]      src_row  = '0;

  panel_px_t  panel_q[$];
  dir_row_t   dir_tab[$];

  bit quiet       = 1'b0;
  int err_cnt     = 0;
  int n_pixels    = 0;
  int n_checked   = 0;
  int n_zone_ends = 0;
  int cycle_cnt   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t timeout, %0d panel pixels still expected", $realtime, panel_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random backpressure, none during the quiet stretch
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(0, 99) >= 30);
  end

  function automatic bit dot_on(int i, int j);
    case (cur_mode)
      dzpu_pkg::MODE_INNER:
        return i > 0 && i < SCALE - 1 && j > 0 && j < SCALE - 1;
      dzpu_pkg::MODE_LOWER_RIGHT:
        return i > 0 && j > 0;
      dzpu_pkg::MODE_DIAGONAL:
        return i == j || i + j == SCALE - 1;
      default:
        return 1'b1;
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t %s mismatch: expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endfunction

  // Works out the SCALE x SCALE panel block of one accepted source pixel.
  task automatic predict_block(input logic [dzpu_pkg::ZONE_W-1:0] zone,
                               input logic [dzpu_pkg::PIXEL_W-1:0] px,
                               input logic typed,
                               input logic [dzpu_pkg::COLOR_W-1:0] t_color,
                               input logic [dzpu_pkg::COORD_W-1:0] t_x0,
                               input logic [dzpu_pkg::COORD_W-1:0] t_y0);
    logic [dzpu_pkg::COLOR_W-1:0] color;
    int x0;
    int y0;
    bit zend;
    panel_px_t p;
    color = (cur_fmt == dzpu_pkg::FMT_RGB565) ? px[15:0] : {px[23:19], px[15:10], px[7:3]};
    x0 = (int'(zone) % ZONES_ACROSS) * ZONE_COLS * SCALE + int'(src_col) * SCALE;
    y0 = (int'(zone) / ZONES_ACROSS) * ZONE_ROWS * SCALE + int'(cur_voff)
         + int'(src_row) * SCALE;
    if (typed) begin
      color = t_color;
      x0 = int'(t_x0);
      y0 = int'(t_y0);
    end
    zend = (src_col == ZONE_COLS - 1) && (src_row == ZONE_ROWS - 1);
    // column offset outer, row offset inner
    for (int i = 0; i < SCALE; i++) begin
      for (int j = 0; j < SCALE; j++) begin
        p.color = dot_on(i, j) ? color : dzpu_pkg::BLACK565;
        p.x     = dzpu_pkg::COORD_W'((x0 + i) & 1023);
        p.y     = dzpu_pkg::COORD_W'((y0 + j) & 1023);
        p.lob   = (i == SCALE - 1) && (j == SCALE - 1);
        p.loz   = p.lob && zend;
        panel_q.push_back(p);
      end
    end
    if (src_col == ZONE_COLS - 1) begin
      src_col = '0;
      src_row = (src_row == ZONE_ROWS - 1) ? 3'd0 : src_row + 3'd1;
    end else begin
      src_col = src_col + 4'd1;
    end
  endtask

  task automatic send_pixel(input logic [dzpu_pkg::ZONE_W-1:0] zone,
                            input logic [dzpu_pkg::PIXEL_W-1:0] px,
                            input logic typed,
                            input logic [dzpu_pkg::COLOR_W-1:0] t_color,
                            input logic [dzpu_pkg::COORD_W-1:0] t_x0,
                            input logic [dzpu_pkg::COORD_W-1:0] t_y0);
    int gap;
    gap = 0;
    // a register write left cfg_we high for exactly one edge; drop it here
    cfg_we <= 1'b0;
    if (!quiet && $urandom_range(0, 99) < 30)
      gap = $urandom_range(1, 24);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, px, zone};
    do @(posedge clk); while (!in_tready);
    predict_block(zone, px, typed, t_color, t_x0, t_y0);
    n_pixels++;
  endtask

  // Writes happen only with the block drained.
  task automatic write_reg(input dzpu_pkg::cfg_idx_t idx, input logic [7:0] val);
    in_tvalid <= 1'b0;
    while (panel_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      dzpu_pkg::CFG_SCALING_MODE:    cur_mode = dzpu_pkg::mode_t'(val[1:0]);
      dzpu_pkg::CFG_INPUT_FORMAT:    cur_fmt  = dzpu_pkg::fmt_t'(val[0]);
      dzpu_pkg::CFG_VERTICAL_OFFSET: cur_voff = val;
      default: ;
    endcase
  endtask

  task automatic add_cfg(input dzpu_pkg::cfg_idx_t idx, input logic [7:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    dir_tab.push_back(r);
  endtask

  task automatic add_px(input logic [dzpu_pkg::ZONE_W-1:0] zone,
                        input logic [dzpu_pkg::PIXEL_W-1:0] px,
                        input logic typed,
                        input logic [dzpu_pkg::COLOR_W-1:0] t_color,
                        input logic [dzpu_pkg::COORD_W-1:0] t_x0,
                        input logic [dzpu_pkg::COORD_W-1:0] t_y0);
    dir_row_t r;
    r = '0;
    r.zone    = zone;
    r.px      = px;
    r.typed   = typed;
    r.t_color = t_color;
    r.t_x0    = t_x0;
    r.t_y0    = t_y0;
    dir_tab.push_back(r);
  endtask

  // Output checker
  always @(posedge clk) begin : mon
    panel_px_t exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      if (panel_q.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected panel pixel: expected none actual %h", $realtime,
                 {out_tdata[35:0], out_tlast, out_tuser});
      end else begin
        exp_px = panel_q.pop_front();
        check_field("out_color", exp_px.color, out_tdata[15:0]);
        check_field("panel_x", 16'(exp_px.x), 16'(out_tdata[25:16]));
        check_field("panel_y", 16'(exp_px.y), 16'(out_tdata[35:26]));
        check_field("last_of_block", 16'(exp_px.lob), 16'(out_tlast));
        check_field("last_of_zone", 16'(exp_px.loz), 16'(out_tuser));
        n_checked++;
        if (out_tuser) n_zone_ends++;
      end
    end
  end

  initial begin
    int left;
    int run;
    logic [dzpu_pkg::ZONE_W-1:0] zone;

    // Rows after reset: full mask, RGB888, no vertical offset, counters at zero
    add_px(5'd0,  24'hFFFFFF, 1'b1, 16'hFFFF, 10'd0,   10'd0);
    add_px(5'd31, 24'h000000, 1'b1, 16'h0000, 10'd452, 10'd96);
    add_px(5'd7,  24'hF80000, 1'b1, 16'hF800, 10'd456, 10'd0);
    add_px(5'd0,  24'h00FC00, 1'b1, 16'h07E0, 10'd12,  10'd0);
    add_px(5'd0,  24'h0000F8, 1'b1, 16'h001F, 10'd16,  10'd0);
    add_px(5'd0,  24'h070307, 1'b1, 16'h0000, 10'd20,  10'd0);  // truncated low bits
    add_cfg(dzpu_pkg::CFG_SCALING_MODE, 8'(dzpu_pkg::MODE_INNER));
    add_px(5'd8,  24'h123456, 1'b0, '0, '0, '0);
    add_px(5'd15, 24'hFFFFFF, 1'b0, '0, '0, '0);
    add_cfg(dzpu_pkg::CFG_INPUT_FORMAT, 8'(dzpu_pkg::FMT_RGB565));
    add_px(5'd1,  24'hFF1234, 1'b0, '0, '0, '0);  // top byte ignored
    add_px(5'd2,  24'h00FFFF, 1'b0, '0, '0, '0);
    add_cfg(dzpu_pkg::CFG_SCALING_MODE, 8'(dzpu_pkg::MODE_LOWER_RIGHT));
    add_cfg(dzpu_pkg::CFG_VERTICAL_OFFSET, 8'hFF);
    add_px(5'd31, 24'hABCDEF, 1'b0, '0, '0, '0);
    add_px(5'd24, 24'h5A5A5A, 1'b0, '0, '0, '0);
    add_cfg(dzpu_pkg::CFG_SCALING_MODE, 8'(dzpu_pkg::MODE_DIAGONAL));
    add_px(5'd16, 24'hFFFFFF, 1'b0, '0, '0, '0);
    add_px(5'd0,  24'h800001, 1'b0, '0, '0, '0);
    add_cfg(dzpu_pkg::CFG_SCALING_MODE, 8'(dzpu_pkg::MODE_FULL));
    add_cfg(dzpu_pkg::CFG_INPUT_FORMAT, 8'(dzpu_pkg::FMT_RGB888));
    add_cfg(dzpu_pkg::CFG_VERTICAL_OFFSET, 8'h80);
    add_px(5'd9,  24'h7F7F7F, 1'b0, '0, '0, '0);
    add_px(5'd31, 24'hFFFFFF, 1'b0, '0, '0, '0);
    add_px(5'd0,  24'h000000, 1'b0, '0, '0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].is_cfg)
        write_reg(dir_tab[k].idx, dir_tab[k].val);
      else
        send_pixel(dir_tab[k].zone, dir_tab[k].px, dir_tab[k].typed,
                   dir_tab[k].t_color, dir_tab[k].t_x0, dir_tab[k].t_y0);
    end

    // Random phases: each mode once per half, format random, offset extremes on two
    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == 4) || (p == 5);
      write_reg(dzpu_pkg::CFG_SCALING_MODE, 8'(p % 4));
      write_reg(dzpu_pkg::CFG_INPUT_FORMAT, 8'($urandom_range(0, 1)));
      write_reg(dzpu_pkg::CFG_VERTICAL_OFFSET,
                (p == 3) ? 8'hFF : (p == 6) ? 8'h00 : 8'($urandom_range(0, 255)));
      left = PHASE_ITEMS;
      while (left > 0) begin
        zone = 5'($urandom_range(0, 31));
        // mostly runs of one zone, sometimes a lone pixel of a stray zone
        run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 40) : 1;
        if (run > left) run = left;
        for (int n = 0; n < run; n++)
          send_pixel(zone, 24'($urandom), 1'b0, '0, '0, '0);
        left -= run;
      end
    end
    quiet = 1'b0;

    in_tvalid <= 1'b0;
    while (panel_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d source pixels through all four masks, both formats, offsets 0 to 255",
             n_pixels);
    $display("checked %0d panel pixels including %0d zone ends", n_checked, n_zone_ends);
    if (err_cnt == 0 && panel_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d panel pixels never arrived", err_cnt, panel_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/dzpu_pkg.sv
design/dzpu_front.sv
design/dzpu_job_fifo.sv
design/dzpu_back.sv
design/dmd_zone_pixel_upscaler.sv
sim/tb_top.sv
